### rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL files of this project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk_i edge, masked while rst_ni is low.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Condition that must never be true out of reset.
`define ASSERT_NEVER(label, cond) \
  `ASSERT_CLK(label, !(cond))

`endif

### rtl/core/hbd_pkg.sv
// ---------------------------------------------------------------------------
// hbd_pkg
// Constants, codes and types of the three-channel H-bridge PWM driver.
// ---------------------------------------------------------------------------
package hbd_pkg;

  localparam int unsigned NUM_MOTORS  = 3;
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned SPEED_W     = 17;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;

  localparam logic [COUNT_WIDTH-1:0] PERIOD_RESET   = COUNT_WIDTH'(36000);
  localparam logic [COUNT_WIDTH-1:0] MAX_DUTY_RESET = COUNT_WIDTH'(36000);
  localparam logic [COUNT_WIDTH-1:0] COMPARE_RESET  = COUNT_WIDTH'(18000);

  localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_W-1:0] OP_SPEED   = 3'd1;
  localparam logic [OP_W-1:0] OP_STOP    = 3'd2;
  localparam logic [OP_W-1:0] OP_ENABLE  = 3'd3;
  localparam logic [OP_W-1:0] OP_DISABLE = 3'd4;

  // register index, taken from paddr[2]
  localparam logic REG_PERIOD   = 1'b0;
  localparam logic REG_MAX_DUTY = 1'b1;

  typedef logic [NUM_MOTORS-1:0] motor_vec_t;

  typedef struct packed {
    motor_vec_t standby;
    motor_vec_t in2;
    motor_vec_t in1;
    motor_vec_t pwm;
  } pins_t;

endpackage

### rtl/core/hbd_core.sv
// ---------------------------------------------------------------------------
// hbd_core
// Counter, compare values, bridge state; one item per cycle with accept_i.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hbd_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic [hbd_pkg::OP_W-1:0]            op_i,
  input  hbd_pkg::motor_vec_t                 mask_i,
  input  logic signed [hbd_pkg::SPEED_W-1:0]  speed_i,
  input  logic                                stop_mode_i,
  input  logic [hbd_pkg::COUNT_WIDTH-1:0]     period_i,
  input  logic [hbd_pkg::COUNT_WIDTH-1:0]     max_duty_i,
  output hbd_pkg::pins_t                      pins_o
);

  logic [hbd_pkg::COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [hbd_pkg::COUNT_WIDTH-1:0] cmp_q [hbd_pkg::NUM_MOTORS];
  logic [hbd_pkg::COUNT_WIDTH-1:0] cmp_d [hbd_pkg::NUM_MOTORS];
  hbd_pkg::motor_vec_t             in1_q, in1_d;
  hbd_pkg::motor_vec_t             in2_q, in2_d;
  hbd_pkg::motor_vec_t             pwm_q, pwm_d;
  hbd_pkg::motor_vec_t             en_q, en_d;

  logic [hbd_pkg::SPEED_W-1:0]     spd_raw;
  logic [hbd_pkg::SPEED_W-1:0]     spd_mag;
  logic [hbd_pkg::COUNT_WIDTH-1:0] spd_sat;
  logic                            spd_neg;
  logic [hbd_pkg::COUNT_WIDTH-1:0] cnt_next;

  assign spd_raw  = $unsigned(speed_i);
  assign spd_neg  = spd_raw[hbd_pkg::SPEED_W-1];
  assign spd_mag  = spd_neg ? (hbd_pkg::SPEED_W'(0) - spd_raw) : spd_raw;
  assign spd_sat  = (spd_mag > {1'b0, max_duty_i}) ? max_duty_i
                                                    : spd_mag[hbd_pkg::COUNT_WIDTH-1:0];
  assign cnt_next = (cnt_q >= period_i) ? '0 : cnt_q + hbd_pkg::COUNT_WIDTH'(1);

  always_comb begin
    cnt_d = cnt_q;
    cmp_d = cmp_q;
    in1_d = in1_q;
    in2_d = in2_q;
    pwm_d = pwm_q;
    en_d  = en_q;
    unique case (op_i)
      hbd_pkg::OP_TICK: begin
        cnt_d = cnt_next;
        if (cnt_q >= period_i) begin
          pwm_d = '1;
        end
        for (int i = 0; i < hbd_pkg::NUM_MOTORS; i++) begin
          if (cmp_q[i] == cnt_next) begin
            pwm_d[i] = 1'b0;
          end
        end
      end
      hbd_pkg::OP_SPEED: begin
        for (int i = 0; i < hbd_pkg::NUM_MOTORS; i++) begin
          if (mask_i[i]) begin
            if (spd_raw == '0) begin
              in1_d[i] = 1'b1;
              in2_d[i] = 1'b1;
            end else begin
              in1_d[i] = spd_neg;
              in2_d[i] = !spd_neg;
              cmp_d[i] = spd_sat;
            end
          end
        end
      end
      hbd_pkg::OP_STOP: begin
        in1_d = stop_mode_i ? (in1_q | mask_i) : (in1_q & ~mask_i);
        in2_d = stop_mode_i ? (in2_q | mask_i) : (in2_q & ~mask_i);
      end
      hbd_pkg::OP_ENABLE:  en_d = en_q | mask_i;
      hbd_pkg::OP_DISABLE: en_d = en_q & ~mask_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      in1_q <= '0;
      in2_q <= '0;
      pwm_q <= '0;
      en_q  <= '0;
      for (int i = 0; i < hbd_pkg::NUM_MOTORS; i++) begin
        cmp_q[i] <= hbd_pkg::COMPARE_RESET;
      end
    end else if (accept_i) begin
      cnt_q <= cnt_d;
      cmp_q <= cmp_d;
      in1_q <= in1_d;
      in2_q <= in2_d;
      pwm_q <= pwm_d;
      en_q  <= en_d;
    end
  end

  assign pins_o = '{standby: en_d, in2: in2_d, in1: in1_d, pwm: pwm_d};

  `ASSERT_CLK(a_cnt_step,
    (accept_i && op_i == hbd_pkg::OP_TICK && cnt_q < period_i)
      |=> (cnt_q == $past(cnt_q) + hbd_pkg::COUNT_WIDTH'(1)))
  `ASSERT_CLK(a_cnt_hold, !(accept_i && op_i == hbd_pkg::OP_TICK) |=> $stable(cnt_q))
  `ASSERT_CLK(a_en_hold,
    !(accept_i && (op_i == hbd_pkg::OP_ENABLE || op_i == hbd_pkg::OP_DISABLE))
      |=> $stable(en_q))

endmodule

### rtl/core/three_channel_hbridge_pwm_driver_top.sv
// ---------------------------------------------------------------------------
// three_channel_hbridge_pwm_driver_top
// Three H-bridge motor drivers sharing one PWM counter, with command stream,
// pin-state result stream and register port.
//
//   channel   direction  contents
//   s_axis    in         tuser: op; tdata: motor_mask, speed, stop_mode
//   m_axis    out        tdata: pwm_pins, in1_pins, in2_pins, standby_pins
//   apb       in/out     period (0x0), max_duty (0x4)
//
// One item per cycle while s_axis_tready is high; its result appears in the
// output register in the cycle after acceptance, or in the skid register
// while the output is stalled. The result queue is an output register plus
// a skid register, so s_axis_tready only drops while both are full.
// Reset clears counter, pins and queue; compare values load 18000.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module three_channel_hbridge_pwm_driver_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [2:0] motor_mask, [19:3] speed, [20] stop_mode, [23:21] zero
  input  logic [hbd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // [2:0] op
  input  logic [hbd_pkg::OP_W-1:0]            s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [2:0] pwm_pins, [5:3] in1_pins, [8:6] in2_pins, [11:9] standby_pins
  output logic [hbd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [hbd_pkg::PADDR_W-1:0]         paddr,
  input  logic [hbd_pkg::PDATA_W-1:0]         pwdata,
  output logic [hbd_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);

  logic [hbd_pkg::COUNT_WIDTH-1:0] period_q, max_duty_q;
  logic                            cfg_wr;
  logic                            accept;
  hbd_pkg::pins_t                  res;
  hbd_pkg::pins_t                  out_q, skid_q;
  logic                            out_vld_q, skid_vld_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= hbd_pkg::PERIOD_RESET;
      max_duty_q <= hbd_pkg::MAX_DUTY_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        hbd_pkg::REG_PERIOD:   period_q   <= pwdata[hbd_pkg::COUNT_WIDTH-1:0];
        hbd_pkg::REG_MAX_DUTY: max_duty_q <= pwdata[hbd_pkg::COUNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == hbd_pkg::REG_MAX_DUTY)
                ? hbd_pkg::PDATA_W'(max_duty_q) : hbd_pkg::PDATA_W'(period_q);

  assign s_axis_tready = !skid_vld_q;
  assign accept        = s_axis_tvalid && s_axis_tready;

  hbd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (s_axis_tuser),
    .mask_i      (s_axis_tdata[2:0]),
    .speed_i     ($signed(s_axis_tdata[19:3])),
    .stop_mode_i (s_axis_tdata[20]),
    .period_i    (period_q),
    .max_duty_i  (max_duty_q),
    .pins_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        if (out_vld_q && !m_axis_tready) begin
          skid_vld_q <= 1'b1;
        end else begin
          out_vld_q <= 1'b1;
        end
      end else if (m_axis_tready) begin
        out_vld_q  <= skid_vld_q;
        skid_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (out_vld_q && !m_axis_tready) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end else if (m_axis_tready && skid_vld_q) begin
      out_q <= skid_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = hbd_pkg::OUT_TDATA_W'(out_q);

  `ASSERT_NEVER(a_skid_alone, skid_vld_q && !out_vld_q)
  `ASSERT_CLK(a_skid_drain, (skid_vld_q && m_axis_tready) |=> (out_vld_q && !skid_vld_q))
  `ASSERT_CLK(a_accept_shows, accept |=> out_vld_q)

endmodule
